[sv/tcdf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcdf_pkg
// shared types and constants of the tabulated cdf time sampler
// ----------------------------------------------------------------------------
package tcdf_pkg;

    localparam int MAX_SLICES_DEF    = 64;
    localparam int MAX_TIME_BINS_DEF = 64;

    localparam int FUNC_W  = 2;
    localparam int IDX_W   = 6;
    localparam int CDF_W   = 17;
    localparam int TIME_W  = 16;
    localparam int DEPTH_W = 13;
    localparam int DRAW_W  = 16;
    localparam int CNT_W   = 7;
    localparam int RECIP_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WR_CDF  = 2'd0,
        FUNC_WR_TIME = 2'd1,
        FUNC_SAMPLE  = 2'd2,
        FUNC_LINE    = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_SLICES = 2'd0,
        REG_ACTIVE_BINS   = 2'd1,
        REG_INV_SLICE_W   = 2'd2,
        REG_INV_LIGHT     = 2'd3
    } cfg_reg_t;

    localparam logic [CNT_W-1:0]   RST_ACTIVE_SLICES = 7'd64;
    localparam logic [CNT_W-1:0]   RST_ACTIVE_BINS   = 7'd64;
    localparam logic [RECIP_W-1:0] RST_INV_SLICE_W   = 16'd4096;
    localparam logic [RECIP_W-1:0] RST_INV_LIGHT     = 16'd1600;

    typedef struct packed {
        logic [CNT_W-1:0]   active_slices;
        logic [CNT_W-1:0]   active_time_bins;
        logic [RECIP_W-1:0] inv_slice_width;
        logic [RECIP_W-1:0] inv_light_speed;
    } cfg_t;

endpackage
`default_nettype wire

[sv/tcdf_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcdf_in_if / tcdf_out_if / tcdf_cfg_if
// valid/ready channels of the sampler
// ----------------------------------------------------------------------------
interface tcdf_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [tcdf_pkg::FUNC_W-1:0]            func;
    logic [tcdf_pkg::IDX_W-1:0]             slice_index;
    logic [tcdf_pkg::IDX_W-1:0]             bin_index;
    logic [tcdf_pkg::CDF_W-1:0]             cdf_value;
    logic signed [tcdf_pkg::TIME_W-1:0]     time_centre;
    logic signed [tcdf_pkg::DEPTH_W-1:0]    depth;
    logic [tcdf_pkg::DRAW_W-1:0]            uniform_draw;
    modport source (output valid, func, slice_index, bin_index, cdf_value, time_centre,
                    depth, uniform_draw, input ready);
    modport sink (input valid, func, slice_index, bin_index, cdf_value, time_centre,
                  depth, uniform_draw, output ready);
endinterface

interface tcdf_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [tcdf_pkg::TIME_W-1:0] prop_time;
    logic [tcdf_pkg::IDX_W-1:0]         chosen_bin;
    modport source (output valid, prop_time, chosen_bin, input ready);
    modport sink (input valid, prop_time, chosen_bin, output ready);
endinterface

interface tcdf_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [tcdf_pkg::CFG_IDX_W-1:0]      index;
    logic [tcdf_pkg::CFG_DATA_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[sv/tcdf_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcdf_regs
// configuration register file
// ----------------------------------------------------------------------------
module tcdf_regs (
    input  wire logic       clk,
    input  wire logic       rst_n,
    tcdf_cfg_if.sink        cfg,
    output tcdf_pkg::cfg_t  regs
);
    tcdf_pkg::cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.active_slices    <= tcdf_pkg::RST_ACTIVE_SLICES;
            regs_reg.active_time_bins <= tcdf_pkg::RST_ACTIVE_BINS;
            regs_reg.inv_slice_width  <= tcdf_pkg::RST_INV_SLICE_W;
            regs_reg.inv_light_speed  <= tcdf_pkg::RST_INV_LIGHT;
        end
        else if (cfg.valid)
        begin
            case (tcdf_pkg::cfg_reg_t'(cfg.index))
                tcdf_pkg::REG_ACTIVE_SLICES:
                    regs_reg.active_slices <= cfg.data[tcdf_pkg::CNT_W-1:0];
                tcdf_pkg::REG_ACTIVE_BINS:
                    regs_reg.active_time_bins <= cfg.data[tcdf_pkg::CNT_W-1:0];
                tcdf_pkg::REG_INV_SLICE_W:
                    regs_reg.inv_slice_width <= cfg.data;
                tcdf_pkg::REG_INV_LIGHT:
                    regs_reg.inv_light_speed <= cfg.data;
                default:
                    regs_reg <= regs_reg;
            endcase
        end
    end
endmodule
`default_nettype wire

[sv/tcdf_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcdf_front
// depth multiply and slice / line time mapping, two register stages
// ----------------------------------------------------------------------------
module tcdf_front #(
    parameter int MAX_SLICES = tcdf_pkg::MAX_SLICES_DEF,
    parameter int SL_W       = 6
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             adv,
    input  wire logic                             in_v,
    input  wire logic [tcdf_pkg::FUNC_W-1:0]      in_func,
    input  wire logic signed [tcdf_pkg::DEPTH_W-1:0] in_depth,
    input  tcdf_pkg::cfg_t                        regs,
    output logic                                  out_v,
    output logic [tcdf_pkg::FUNC_W-1:0]           out_func,
    output logic [SL_W-1:0]                       out_slice,
    output logic signed [tcdf_pkg::TIME_W-1:0]    out_line,
    output logic                                  busy
);
    localparam int PW = tcdf_pkg::DEPTH_W + tcdf_pkg::RECIP_W + 2;
    localparam int QW = PW - 16;

    logic                                v1_reg;
    logic [tcdf_pkg::FUNC_W-1:0]         f1_reg;
    logic signed [PW-1:0]                ps_reg;
    logic signed [PW-1:0]                pl_reg;
    logic                                v2_reg;
    logic [tcdf_pkg::FUNC_W-1:0]         f2_reg;
    logic [SL_W-1:0]                     sl_reg;
    logic signed [tcdf_pkg::TIME_W-1:0]  ln_reg;
    logic signed [QW-1:0]                qs;
    logic signed [QW-1:0]                ql;
    logic [tcdf_pkg::CNT_W-1:0]          ns;
    logic [SL_W-1:0]                     sl_next;
    logic signed [tcdf_pkg::TIME_W-1:0]  ln_next;

    always_comb
    begin
        // arithmetic shift floors the Q16 product
        qs = QW'(ps_reg >>> 16);
        ql = QW'(pl_reg >>> 16);
        ns = regs.active_slices;
        if (ns == '0)
            ns = tcdf_pkg::CNT_W'(1);
        else if (32'(ns) > MAX_SLICES)
            ns = tcdf_pkg::CNT_W'(MAX_SLICES);
        if (qs <= 0)
            sl_next = '0;
        else if (qs > QW'(ns) - QW'(1))
            sl_next = SL_W'(ns - tcdf_pkg::CNT_W'(1));
        else
            sl_next = SL_W'(qs);
        if (int'(ql) > 32767)
            ln_next = 16'sh7fff;
        else if (int'(ql) < -32768)
            ln_next = -16'sh8000;
        else
            ln_next = tcdf_pkg::TIME_W'(ql);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_v;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_reg <= in_func;
            ps_reg <= PW'(in_depth) * $signed({2'b0, regs.inv_slice_width});
            pl_reg <= PW'(in_depth) * $signed({2'b0, regs.inv_light_speed});
            f2_reg <= f1_reg;
            sl_reg <= sl_next;
            ln_reg <= ln_next;
        end
    end

    assign out_v     = v2_reg;
    assign out_func  = f2_reg;
    assign out_slice = sl_reg;
    assign out_line  = ln_reg;
    assign busy      = v1_reg || v2_reg;
endmodule
`default_nettype wire

[sv/tcdf_search.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcdf_search
// cdf column and time table memories; one search step per two stages
// ----------------------------------------------------------------------------
module tcdf_search #(
    parameter int MAX_SLICES    = tcdf_pkg::MAX_SLICES_DEF,
    parameter int MAX_TIME_BINS = tcdf_pkg::MAX_TIME_BINS_DEF,
    parameter int SL_W          = 6,
    parameter int BIN_W         = 6,
    parameter int LEN_W         = 7,
    parameter int STEPS         = 7
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             adv,
    input  wire logic                             wr_cdf,
    input  wire logic                             wr_time,
    input  wire logic [tcdf_pkg::IDX_W-1:0]       wr_slice,
    input  wire logic [tcdf_pkg::IDX_W-1:0]       wr_bin,
    input  wire logic [tcdf_pkg::CDF_W-1:0]       wr_cdf_val,
    input  wire logic [tcdf_pkg::TIME_W-1:0]      wr_time_val,
    input  wire logic                             in_v,
    input  wire logic [tcdf_pkg::FUNC_W-1:0]      in_func,
    input  wire logic [SL_W-1:0]                  in_slice,
    input  wire logic signed [tcdf_pkg::TIME_W-1:0] in_line,
    input  wire logic [tcdf_pkg::DRAW_W-1:0]      in_draw,
    input  tcdf_pkg::cfg_t                        regs,
    output logic                                  out_v,
    output logic signed [tcdf_pkg::TIME_W-1:0]    out_time,
    output logic [BIN_W-1:0]                      out_bin,
    output logic                                  busy
);
    localparam int AW = SL_W + BIN_W;
    localparam int LW = LEN_W + 1;

    logic [tcdf_pkg::CDF_W-1:0]  cdf_mem [STEPS][2**AW];
    logic [tcdf_pkg::TIME_W-1:0] time_mem [MAX_TIME_BINS];

    logic                               v_reg   [STEPS+1];
    logic [tcdf_pkg::FUNC_W-1:0]        f_reg   [STEPS+1];
    logic [SL_W-1:0]                    s_reg   [STEPS+1];
    logic signed [tcdf_pkg::TIME_W-1:0] l_reg   [STEPS+1];
    logic [tcdf_pkg::DRAW_W-1:0]        d_reg   [STEPS+1];
    logic [LW-1:0]                      lo_reg  [STEPS+1];
    logic [LW-1:0]                      len_reg [STEPS+1];
    logic                               mv_reg   [STEPS];
    logic [tcdf_pkg::FUNC_W-1:0]        mf_reg   [STEPS];
    logic [SL_W-1:0]                    ms_reg   [STEPS];
    logic signed [tcdf_pkg::TIME_W-1:0] ml_reg   [STEPS];
    logic [tcdf_pkg::DRAW_W-1:0]        md_reg   [STEPS];
    logic [LW-1:0]                      mlo_reg  [STEPS];
    logic [LW-1:0]                      mlen_reg [STEPS];
    logic [tcdf_pkg::CDF_W-1:0]         rd_reg  [STEPS];
    logic [LW-1:0]                      nb;
    logic                               vo_reg;
    logic signed [tcdf_pkg::TIME_W-1:0] to_reg;
    logic signed [tcdf_pkg::TIME_W-1:0] lo_line_reg;
    logic                               line_reg;
    logic [BIN_W-1:0]                   bo_reg;
    logic [BIN_W-1:0]                   bin_fin;
    logic [LW-1:0]                      lo_fin;

    always_comb
    begin
        nb = LW'(regs.active_time_bins);
        if (nb == '0)
            nb = LW'(1);
        else if (32'(nb) > MAX_TIME_BINS)
            nb = LW'(MAX_TIME_BINS);
        lo_fin = lo_reg[STEPS];
        if (lo_fin > nb - LW'(1))
            lo_fin = nb - LW'(1);
        bin_fin = BIN_W'(lo_fin);
    end

    always_comb
    begin
        busy = 1'b0;
        for (int k = 0; k <= STEPS; k++)
            busy = busy | v_reg[k];
        for (int k = 0; k < STEPS; k++)
            busy = busy | mv_reg[k];
    end

    // each step owns a copy of the table so every stage reads one address
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < STEPS; k++)
        begin
            if (wr_cdf && 32'(wr_slice) < MAX_SLICES && 32'(wr_bin) < MAX_TIME_BINS)
                cdf_mem[k][{SL_W'(wr_slice), BIN_W'(wr_bin)}] <= wr_cdf_val;
        end
        if (wr_time && 32'(wr_bin) < MAX_TIME_BINS)
            time_mem[BIN_W'(wr_bin)] <= wr_time_val;
    end

    // step k: address issued from stage k, compare with data in the next stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= STEPS; k++)
                v_reg[k] <= 1'b0;
            for (int k = 0; k < STEPS; k++)
                mv_reg[k] <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_v;
            for (int k = 0; k < STEPS; k++)
            begin
                mv_reg[k]  <= v_reg[k];
                v_reg[k+1] <= mv_reg[k];
            end
            vo_reg <= v_reg[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_reg[0]   <= in_func;
            s_reg[0]   <= in_slice;
            l_reg[0]   <= in_line;
            d_reg[0]   <= in_draw;
            lo_reg[0]  <= '0;
            len_reg[0] <= nb;
            for (int k = 0; k < STEPS; k++)
            begin
                rd_reg[k] <= cdf_mem[k][AW'({s_reg[k], BIN_W'(lo_reg[k] + (len_reg[k] >> 1))})];
                mf_reg[k]   <= f_reg[k];
                ms_reg[k]   <= s_reg[k];
                ml_reg[k]   <= l_reg[k];
                md_reg[k]   <= d_reg[k];
                mlo_reg[k]  <= lo_reg[k];
                mlen_reg[k] <= len_reg[k];
            end
            for (int k = 0; k < STEPS; k++)
            begin
                f_reg[k+1] <= mf_reg[k];
                s_reg[k+1] <= ms_reg[k];
                l_reg[k+1] <= ml_reg[k];
                d_reg[k+1] <= md_reg[k];
                if (mlen_reg[k] == '0)
                begin
                    lo_reg[k+1]  <= mlo_reg[k];
                    len_reg[k+1] <= '0;
                end
                else if (rd_reg[k] < tcdf_pkg::CDF_W'(md_reg[k]))
                begin
                    lo_reg[k+1]  <= mlo_reg[k] + (mlen_reg[k] >> 1) + LW'(1);
                    len_reg[k+1] <= mlen_reg[k] - (mlen_reg[k] >> 1) - LW'(1);
                end
                else
                begin
                    lo_reg[k+1]  <= mlo_reg[k];
                    len_reg[k+1] <= mlen_reg[k] >> 1;
                end
            end
            to_reg      <= time_mem[bin_fin];
            lo_line_reg <= l_reg[STEPS];
            line_reg    <= (tcdf_pkg::func_t'(f_reg[STEPS]) == tcdf_pkg::FUNC_LINE);
            bo_reg      <= (tcdf_pkg::func_t'(f_reg[STEPS]) == tcdf_pkg::FUNC_LINE)
                           ? '0 : bin_fin;
        end
    end

    assign out_v    = vo_reg;
    assign out_time = line_reg ? lo_line_reg : to_reg;
    assign out_bin  = bo_reg;
endmodule
`default_nettype wire

[sv/tabulated_cdf_time_sampler.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tabulated_cdf_time_sampler
// path: front stages, search steps, time table read, output register, in that order
// throughput: one sample or line word per cycle while the output is taken; a load word waits until no
// sample or line word is in flight, then takes effect as it is accepted
// the search stage pipeline sets latency; cdf memories are one copy per step, the time table is single
// reset clears valid bits and loads register defaults; tables are undefined until written
// ----------------------------------------------------------------------------
module tabulated_cdf_time_sampler #(
    parameter int MAX_SLICES    = tcdf_pkg::MAX_SLICES_DEF,
    parameter int MAX_TIME_BINS = tcdf_pkg::MAX_TIME_BINS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tcdf_in_if.sink     in_ch,
    tcdf_out_if.source  out_ch,
    tcdf_cfg_if.sink    cfg
);
    localparam int SL_W  = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
    localparam int BIN_W = $clog2(MAX_TIME_BINS);
    localparam int LEN_W = $clog2(MAX_TIME_BINS + 1);
    localparam int STEPS = LEN_W;
    localparam int DLY   = 2;

    tcdf_pkg::cfg_t                      regs;
    logic                                adv;
    logic                                acc;
    logic                                is_wr;
    logic                                busy_f;
    logic                                busy_s;
    logic                                fv;
    logic [tcdf_pkg::FUNC_W-1:0]         ff;
    logic [SL_W-1:0]                     fs;
    logic signed [tcdf_pkg::TIME_W-1:0]  fl;
    logic [tcdf_pkg::DRAW_W-1:0]         dd_reg [DLY];
    logic                                sv_v;
    logic signed [tcdf_pkg::TIME_W-1:0]  sv_t;
    logic [BIN_W-1:0]                    sv_b;
    logic                                ov_reg;
    logic signed [tcdf_pkg::TIME_W-1:0]  ot_reg;
    logic [BIN_W-1:0]                    ob_reg;

    // pipeline moves when output slot is empty or being taken
    // loads wait until no sample or line word can still read the tables
    assign adv          = !ov_reg || out_ch.ready;
    assign is_wr        = tcdf_pkg::func_t'(in_ch.func) inside
                          {tcdf_pkg::FUNC_WR_CDF, tcdf_pkg::FUNC_WR_TIME};
    assign in_ch.ready  = adv && !(is_wr && (busy_f || busy_s));
    assign acc          = in_ch.valid && in_ch.ready;

    tcdf_regs u_regs (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg),
        .regs (regs)
    );

    tcdf_front #(.MAX_SLICES(MAX_SLICES), .SL_W(SL_W)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_v     (acc && in_ch.func[1]),
        .in_func  (in_ch.func),
        .in_depth (in_ch.depth),
        .regs     (regs),
        .out_v    (fv),
        .out_func (ff),
        .out_slice(fs),
        .out_line (fl),
        .busy     (busy_f)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dd_reg[0] <= in_ch.uniform_draw;
            for (int k = 1; k < DLY; k++)
                dd_reg[k] <= dd_reg[k-1];
        end
    end

    tcdf_search #(
        .MAX_SLICES(MAX_SLICES), .MAX_TIME_BINS(MAX_TIME_BINS),
        .SL_W(SL_W), .BIN_W(BIN_W), .LEN_W(LEN_W), .STEPS(STEPS)
    ) u_search (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .wr_cdf     (acc && tcdf_pkg::func_t'(in_ch.func) == tcdf_pkg::FUNC_WR_CDF),
        .wr_time    (acc && tcdf_pkg::func_t'(in_ch.func) == tcdf_pkg::FUNC_WR_TIME),
        .wr_slice   (in_ch.slice_index),
        .wr_bin     (in_ch.bin_index),
        .wr_cdf_val (in_ch.cdf_value),
        .wr_time_val(in_ch.time_centre),
        .in_v       (fv),
        .in_func    (ff),
        .in_slice   (fs),
        .in_line    (fl),
        .in_draw    (dd_reg[DLY-1]),
        .regs       (regs),
        .out_v      (sv_v),
        .out_time   (sv_t),
        .out_bin    (sv_b),
        .busy       (busy_s)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (adv)
            ov_reg <= sv_v;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ot_reg <= sv_t;
            ob_reg <= sv_b;
        end
    end

    assign out_ch.valid      = ov_reg;
    assign out_ch.prop_time  = ot_reg;
    assign out_ch.chosen_bin = tcdf_pkg::IDX_W'(ob_reg);
endmodule
`default_nettype wire

[dv/tcdf_tb_if.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tcdf_tb_if
// The testbench connects to the sampler through the channel interfaces
// declared with the RTL in sv/tcdf_if.sv. This file holds the testbench's own
// word types: one input word with its expected result, and one expected
// result as it is stored for the output checker.
// ----------------------------------------------------------------------------
package tcdf_tb_types;
    import tcdf_pkg::*;

    typedef struct {
        func_t                    func;
        logic [IDX_W-1:0]         slice_index;
        logic [IDX_W-1:0]         bin_index;
        logic [CDF_W-1:0]         cdf_value;
        logic signed [TIME_W-1:0] time_centre;
        logic signed [DEPTH_W-1:0] depth;
        logic [DRAW_W-1:0]        uniform_draw;
        bit                       hold;
        bit                       has_res;
        logic signed [TIME_W-1:0] exp_time;
        logic [IDX_W-1:0]         exp_bin;
    } word_t;

    typedef struct {
        logic signed [TIME_W-1:0] prop_time;
        logic [IDX_W-1:0]         chosen_bin;
    } sample_res_t;
endpackage

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the tabulated-CDF time sampler. Stimulus loads time and CDF tables,
// then runs sample and line words under several register settings. A local
// predictor computes every expected result; the monitor compares each output
// word in order. Columns are always loaded before a sample can read them.
// ----------------------------------------------------------------------------
module tb_top;
    import tcdf_pkg::*;
    import tcdf_tb_types::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tcdf_in_if  in_if();
    tcdf_out_if out_if();
    tcdf_cfg_if cfg_if();

    tabulated_cdf_time_sampler dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if),
        .out_ch (out_if),
        .cfg    (cfg_if)
    );

    always #4 clk = ~clk;

    // predictor state
    logic [CDF_W-1:0]  cdf_mem  [64][64];
    bit                cdf_seen [64][64];
    logic [TIME_W-1:0] time_mem [64];
    int unsigned n_slices, n_bins, slice_recip, light_recip;

    word_t       word_q [$];
    sample_res_t result_q [$];
    word_t       cur_word;
    int          errors = 0;
    int          fill_words = 0;
    int          src_idle = 38;
    int          snk_idle = 58;
    int          depth_win = 1023;

    function automatic int unsigned sat_count(int unsigned v);
        if (v < 1) return 1;
        if (v > 64) return 64;
        return v;
    endfunction

    function automatic int unsigned slice_of(logic signed [DEPTH_W-1:0] d);
        longint s;
        int unsigned ns;
        ns = sat_count(n_slices);
        s = (longint'(d) * longint'(slice_recip)) >>> 16;
        if (s <= 0) return 0;
        if (s > ns - 1) return ns - 1;
        return int'(s);
    endfunction

    // predicts and applies one word, then queues it for the driver
    task automatic issue(word_t w);
        int unsigned slc, nb, lo, len, half;
        longint t;
        w.has_res = 0;
        case (w.func)
            FUNC_WR_CDF:
            begin
                cdf_mem[w.slice_index][w.bin_index] = w.cdf_value;
                cdf_seen[w.slice_index][w.bin_index] = 1;
            end
            FUNC_WR_TIME:
                time_mem[w.bin_index] = w.time_centre;
            FUNC_SAMPLE:
            begin
                nb = sat_count(n_bins);
                slc = slice_of(w.depth);
                lo = 0;
                len = nb;
                while (len > 0)
                begin
                    half = len >> 1;
                    if (cdf_mem[slc][lo + half] < {1'b0, w.uniform_draw})
                    begin
                        lo += half + 1;
                        len -= half + 1;
                    end
                    else
                        len = half;
                end
                if (lo > nb - 1) lo = nb - 1;
                w.has_res = 1;
                w.exp_time = time_mem[lo];
                w.exp_bin = lo[IDX_W-1:0];
            end
            default:
            begin
                t = (longint'(w.depth) * longint'(light_recip)) >>> 16;
                if (t > 32767) t = 32767;
                if (t < -32768) t = -32768;
                w.has_res = 1;
                w.exp_time = t[TIME_W-1:0];
                w.exp_bin = '0;
            end
        endcase
        word_q = {word_q, w};
    endtask

    function automatic word_t blank();
        word_t w;
        w.func = FUNC_LINE;
        w.slice_index = IDX_W'($urandom);
        w.bin_index = IDX_W'($urandom);
        w.cdf_value = CDF_W'($urandom_range(0, 65536));
        w.time_centre = TIME_W'($urandom);
        w.depth = DEPTH_W'($urandom);
        w.uniform_draw = DRAW_W'($urandom);
        w.hold = 0;
        w.has_res = 0;
        w.exp_time = '0;
        w.exp_bin = '0;
        return w;
    endfunction

    // loads the active entries of a column (n_bins saturated to 1..64): ramp, step to one, or all low
    task automatic fill_column(int unsigned s, int kind);
        word_t w;
        int unsigned v, nb;
        v = 0;
        nb = sat_count(n_bins);
        for (int b = 0; b < nb; b++)
        begin
            w = blank();
            w.func = FUNC_WR_CDF;
            w.slice_index = IDX_W'(s);
            w.bin_index = IDX_W'(b);
            if (kind == 1)
                v = (b < nb / 2) ? 0 : 65536;
            else if (kind == 2)
                v = $urandom_range(0, 1000);
            else
            begin
                v += $urandom_range(0, 2 * 65536 / nb);
                if (v > 65536 || b == nb - 1) v = 65536;
            end
            w.cdf_value = CDF_W'(v);
            issue(w);
            fill_words++;
        end
    endtask

    task automatic sample(logic signed [DEPTH_W-1:0] d, logic [DRAW_W-1:0] u);
        word_t w;
        int unsigned s;
        bit ok;
        s = slice_of(d);
        ok = 1;
        for (int b = 0; b < sat_count(n_bins); b++)
            if (!cdf_seen[s][b]) ok = 0;
        if (!ok && fill_words < 1400)
        begin
            fill_column(s, 0);
            ok = 1;
        end
        w = blank();
        w.func = ok ? FUNC_SAMPLE : FUNC_LINE;
        w.depth = d;
        w.uniform_draw = u;
        issue(w);
    endtask

    task automatic line(logic signed [DEPTH_W-1:0] d);
        word_t w;
        w = blank();
        w.func = FUNC_LINE;
        w.depth = d;
        issue(w);
    endtask

    task automatic drain();
        do @(posedge clk);
        while (word_q.size() != 0 || in_if.valid || result_q.size() != 0);
        repeat (30) @(posedge clk);
    endtask

    task automatic cfg_write(cfg_reg_t idx, int unsigned val);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val[CFG_DATA_W-1:0];
        do @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            REG_ACTIVE_SLICES: n_slices = val & 7'h7f;
            REG_ACTIVE_BINS:   n_bins = val & 7'h7f;
            REG_INV_SLICE_W:   slice_recip = val & 16'hffff;
            default:           light_recip = val & 16'hffff;
        endcase
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_if.valid        <= 1'b0;
            in_if.func         <= FUNC_WR_CDF;
            in_if.slice_index  <= '0;
            in_if.bin_index    <= '0;
            in_if.cdf_value    <= '0;
            in_if.time_centre  <= '0;
            in_if.depth        <= '0;
            in_if.uniform_draw <= '0;
        end
        else
        begin
            if (in_if.valid && in_if.ready && cur_word.has_res)
                result_q = {result_q, sample_res_t'{cur_word.exp_time, cur_word.exp_bin}};
            if (!in_if.valid || in_if.ready)
            begin
                if (word_q.size() != 0 && $urandom_range(0, 99) >= src_idle
                    && !(word_q[0].hold && (result_q.size() != 0 ||
                         (in_if.valid && cur_word.has_res))))
                begin
                    cur_word = word_q.pop_front();
                    in_if.valid        <= 1'b1;
                    in_if.func         <= cur_word.func;
                    in_if.slice_index  <= cur_word.slice_index;
                    in_if.bin_index    <= cur_word.bin_index;
                    in_if.cdf_value    <= cur_word.cdf_value;
                    in_if.time_centre  <= cur_word.time_centre;
                    in_if.depth        <= cur_word.depth;
                    in_if.uniform_draw <= cur_word.uniform_draw;
                end
                else
                    in_if.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            out_if.ready <= 1'b0;
        else
        begin
            if (out_if.valid && out_if.ready)
            begin
                if (result_q.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected word: time %0d bin %0d", $realtime,
                             out_if.prop_time, out_if.chosen_bin);
                end
                else
                begin
                    sample_res_t e;
                    e = result_q.pop_front();
                    if (out_if.prop_time !== e.prop_time)
                    begin
                        errors++;
                        $display("%0t prop_time expected %0d actual %0d", $realtime,
                                 e.prop_time, out_if.prop_time);
                    end
                    if (out_if.chosen_bin !== e.chosen_bin)
                    begin
                        errors++;
                        $display("%0t chosen_bin expected %0d actual %0d", $realtime,
                                 e.chosen_bin, out_if.chosen_bin);
                    end
                end
            end
            out_if.ready <= ($urandom_range(0, 99) >= snk_idle);
        end
    end

    initial
    begin
        #8_000_000;
        $display("tabulated_cdf_time_sampler verification failed");
        $finish;
    end

    initial
    begin
        word_t w;
        int unsigned r;
        logic signed [DEPTH_W-1:0] d;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_ACTIVE_SLICES;
        cfg_if.data = '0;
        n_slices = RST_ACTIVE_SLICES;
        n_bins = RST_ACTIVE_BINS;
        slice_recip = RST_INV_SLICE_W;
        light_recip = RST_INV_LIGHT;
        foreach (cdf_seen[i, j]) cdf_seen[i][j] = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // table loads and directed words at reset settings
        for (int b = 0; b < 64; b++)
        begin
            w = blank();
            w.func = FUNC_WR_TIME;
            w.bin_index = IDX_W'(b);
            if (b == 0) w.time_centre = TIME_W'(-32768);
            if (b == 63) w.time_centre = TIME_W'(32767);
            issue(w);
        end
        fill_column(0, 0);
        fill_column(63, 1);
        fill_column(5, 2);
        sample(DEPTH_W'(-4096), DRAW_W'(0));
        sample(DEPTH_W'(0), 16'hffff);
        sample(DEPTH_W'(4095), 16'hffff);
        sample(DEPTH_W'(4095), DRAW_W'(0));
        sample(DEPTH_W'(4095), DRAW_W'(1));
        sample(DEPTH_W'(85), DRAW_W'(60000));
        line(DEPTH_W'(-4096));
        line(DEPTH_W'(4095));
        line(DEPTH_W'(0));
        line(DEPTH_W'(-1));
        drain();

        for (int ph = 1; ph <= 6; ph++)
        begin
            case (ph)
                1: begin cfg_write(REG_ACTIVE_SLICES, 8); cfg_write(REG_ACTIVE_BINS, 8);
                         cfg_write(REG_INV_SLICE_W, 65535);
                         cfg_write(REG_INV_LIGHT, 65535); depth_win = 40; end
                2: begin cfg_write(REG_ACTIVE_SLICES, 1); cfg_write(REG_ACTIVE_BINS, 1);
                         cfg_write(REG_INV_SLICE_W, 0);
                         cfg_write(REG_INV_LIGHT, 0); depth_win = 4095; end
                3: begin cfg_write(REG_ACTIVE_SLICES, 127); cfg_write(REG_ACTIVE_BINS, 0);
                         cfg_write(REG_INV_SLICE_W, 300);
                         cfg_write(REG_INV_LIGHT, 40000); depth_win = 4095; end
                4: begin cfg_write(REG_ACTIVE_SLICES, 64); cfg_write(REG_ACTIVE_BINS, 64);
                         cfg_write(REG_INV_SLICE_W, 4096);
                         cfg_write(REG_INV_LIGHT, 1600); depth_win = 60; end
                5: begin cfg_write(REG_ACTIVE_SLICES, 16); cfg_write(REG_ACTIVE_BINS, 5);
                         cfg_write(REG_INV_SLICE_W, 20000);
                         cfg_write(REG_INV_LIGHT, 12345); depth_win = 60; end
                default: begin cfg_write(REG_ACTIVE_SLICES, 3);
                         cfg_write(REG_ACTIVE_BINS, 64);
                         cfg_write(REG_INV_SLICE_W, 1);
                         cfg_write(REG_INV_LIGHT, 32768); depth_win = 4095; end
            endcase
            src_idle = (ph <= 2) ? 38 : (ph <= 4) ? 58 : 0;
            snk_idle = (ph <= 2) ? 58 : (ph <= 4) ? 38 : 0;
            for (int k = 0; k < 180; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 70) d = DEPTH_W'($urandom_range(0, depth_win));
                else d = DEPTH_W'($urandom);
                if (ph == 2 && k == 90)
                begin
                    // sender waits here until every pending result is back
                    w = blank();
                    w.func = FUNC_LINE;
                    w.depth = d;
                    w.hold = 1;
                    issue(w);
                end
                if (r < 45)
                    sample(d, DRAW_W'($urandom));
                else if (r < 75)
                    line(d);
                else
                begin
                    w = blank();
                    w.func = (r < 88) ? FUNC_WR_CDF : FUNC_WR_TIME;
                    issue(w);
                end
            end
            drain();
        end

        if (errors == 0)
            $display("tabulated_cdf_time_sampler verification clean");
        else
            $display("tabulated_cdf_time_sampler verification failed");
        $finish;
    end
endmodule
